// ----- rtl/core/tcpq_pkg.sv -----
package tcpq_pkg;

  localparam int UID_W    = 32;
  localparam int STATUS_W = 2;

  // request codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic load_ram;  // capture the memory read data into the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic needs_read;  // current request is a remove that finds an entry
  } stat_t;

endpackage

// ----- rtl/core/two_class_priority_queue.sv -----
// Two-class priority queue of 32-bit process ids.
// Input channel: in_valid / in_stall with in_func (insert or remove), in_uid
// and in_urgent. A beat is taken on a clock edge with in_valid high and
// in_stall low. Each request gives exactly one result beat on out_valid /
// out_stall carrying out_status, out_out_valid, out_uid and out_urgent.
// Inserts go to the tail of the urgent or normal class; a remove returns the
// oldest urgent id, else the oldest normal id. A full class drops the insert
// with status full; a remove on an empty queue returns status empty.
// Timing: an insert or empty remove shows its result in the cycle after it is
// taken; a remove that finds an entry passes through the registered read port
// of the entry memory and then the result register.
// Throughput: one insert per cycle while the receiver keeps out_stall low. A
// remove that finds an entry takes no new beat during its memory read. A new
// beat is taken in the same cycle the previous result leaves.
// Reset (rst_n low at a clock edge) empties both classes; stored ids are not
// cleared. While a result waits with out_stall high, the result holds and
// in_stall stays high.
module two_class_priority_queue #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_func,
  input  logic signed [tcpq_pkg::UID_W-1:0] in_uid,
  input  logic                              in_urgent,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tcpq_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_out_valid,
  output logic signed [tcpq_pkg::UID_W-1:0] out_uid,
  output logic                              out_urgent
);

  tcpq_pkg::cmd_t  cmd;
  tcpq_pkg::stat_t stat;

  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcpq_dp #(
    .CLASS_DEPTH (CLASS_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_func       (in_func),
    .in_uid        (in_uid),
    .in_urgent     (in_urgent),
    .out_status    (out_status),
    .out_out_valid (out_out_valid),
    .out_uid       (out_uid),
    .out_urgent    (out_urgent)
  );

endmodule

// ----- rtl/core/tcpq_ram.sv -----
module tcpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/tcpq_ctrl.sv -----
module tcpq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  tcpq_pkg::stat_t       stat,
  output tcpq_pkg::cmd_t        cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESULT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready;
  logic   take;

  // accept when empty, or when the waiting result leaves in this cycle
  assign in_ready  = (state_r == ST_IDLE) || ((state_r == ST_RESULT) && !out_stall);
  assign in_stall  = !in_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = (state_r == ST_RESULT);

  assign cmd.take     = take;
  assign cmd.load_ram = (state_r == ST_READ);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          state_nxt = stat.needs_read ? ST_READ : ST_RESULT;
        end
      end
      ST_READ: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (take) begin
          state_nxt = stat.needs_read ? ST_READ : ST_RESULT;
        end else if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_read_follows_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> $past(take && stat.needs_read))
    else $error("memory read state entered without a remove that finds an entry");

  a_read_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_RESULT))
    else $error("read data not presented in the cycle after the read");

  a_no_take_while_reading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |-> !take)
    else $error("input beat taken while a memory read is pending");

endmodule

// ----- rtl/core/tcpq_dp.sv -----
module tcpq_dp #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcpq_pkg::cmd_t                    cmd,
  output tcpq_pkg::stat_t                   stat,
  input  logic                              in_func,
  input  logic signed [tcpq_pkg::UID_W-1:0] in_uid,
  input  logic                              in_urgent,
  output logic [tcpq_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_out_valid,
  output logic signed [tcpq_pkg::UID_W-1:0] out_uid,
  output logic                              out_urgent
);

  localparam int PW    = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CW    = $clog2(CLASS_DEPTH + 1);
  localparam int DEPTH = 2 * CLASS_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [PW-1:0] urg_head_r, urg_head_nxt, urg_tail_r, urg_tail_nxt;
  logic [PW-1:0] nrm_head_r, nrm_head_nxt, nrm_tail_r, nrm_tail_nxt;
  logic [CW-1:0] urg_cnt_r, urg_cnt_nxt, nrm_cnt_r, nrm_cnt_nxt;

  logic urg_full, nrm_full, urg_empty, nrm_empty;
  logic is_insert, is_remove;
  logic do_ins_urg, do_ins_nrm, do_rem_urg, do_rem_nrm;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [tcpq_pkg::UID_W-1:0] ram_rdata;

  logic [tcpq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic                          vld_r, vld_nxt;
  logic [tcpq_pkg::UID_W-1:0]    uid_r, uid_nxt;
  logic                          urg_r, urg_nxt;
  logic                          sel_urg_r, sel_urg_nxt;

  function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
    return (p == PW'(CLASS_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic urg, input logic [PW-1:0] p);
    return AW'(p) + (urg ? AW'(0) : AW'(CLASS_DEPTH));
  endfunction

  // class occupancy flags
  assign urg_full  = (urg_cnt_r == CW'(CLASS_DEPTH));
  assign nrm_full  = (nrm_cnt_r == CW'(CLASS_DEPTH));
  assign urg_empty = (urg_cnt_r == '0);
  assign nrm_empty = (nrm_cnt_r == '0);

  // decode the request
  assign is_insert  = (in_func == tcpq_pkg::FUNC_INSERT);
  assign is_remove  = (in_func == tcpq_pkg::FUNC_REMOVE);
  assign do_ins_urg = cmd.take && is_insert && in_urgent && !urg_full;
  assign do_ins_nrm = cmd.take && is_insert && !in_urgent && !nrm_full;
  assign do_rem_urg = cmd.take && is_remove && !urg_empty;
  assign do_rem_nrm = cmd.take && is_remove && urg_empty && !nrm_empty;

  assign stat.needs_read = is_remove && !(urg_empty && nrm_empty);

  // memory ports
  assign ram_we    = do_ins_urg || do_ins_nrm;
  assign ram_waddr = in_urgent ? slot_addr(1'b1, urg_tail_r) : slot_addr(1'b0, nrm_tail_r);
  assign ram_re    = do_rem_urg || do_rem_nrm;
  assign ram_raddr = urg_empty ? slot_addr(1'b0, nrm_head_r) : slot_addr(1'b1, urg_head_r);

  tcpq_ram #(
    .WIDTH (tcpq_pkg::UID_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_uid),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // advance pointers and counts
  always_comb begin
    urg_head_nxt = urg_head_r;
    urg_tail_nxt = urg_tail_r;
    urg_cnt_nxt  = urg_cnt_r;
    nrm_head_nxt = nrm_head_r;
    nrm_tail_nxt = nrm_tail_r;
    nrm_cnt_nxt  = nrm_cnt_r;
    if (do_ins_urg) begin
      urg_tail_nxt = next_slot(urg_tail_r);
      urg_cnt_nxt  = urg_cnt_r + CW'(1);
    end
    if (do_ins_nrm) begin
      nrm_tail_nxt = next_slot(nrm_tail_r);
      nrm_cnt_nxt  = nrm_cnt_r + CW'(1);
    end
    if (do_rem_urg) begin
      urg_head_nxt = next_slot(urg_head_r);
      urg_cnt_nxt  = urg_cnt_r - CW'(1);
    end
    if (do_rem_nrm) begin
      nrm_head_nxt = next_slot(nrm_head_r);
      nrm_cnt_nxt  = nrm_cnt_r - CW'(1);
    end
  end

  // build the result beat
  always_comb begin
    status_nxt  = status_r;
    vld_nxt     = vld_r;
    uid_nxt     = uid_r;
    urg_nxt     = urg_r;
    sel_urg_nxt = sel_urg_r;
    if (cmd.load_ram) begin
      status_nxt = tcpq_pkg::STATUS_OK;
      vld_nxt    = 1'b1;
      uid_nxt    = ram_rdata;
      urg_nxt    = sel_urg_r;
    end else if (cmd.take) begin
      vld_nxt     = 1'b0;
      uid_nxt     = '0;
      urg_nxt     = 1'b0;
      sel_urg_nxt = !urg_empty;
      if (is_insert) begin
        status_nxt = (in_urgent ? urg_full : nrm_full) ? tcpq_pkg::STATUS_FULL
                                                       : tcpq_pkg::STATUS_OK;
      end else begin
        status_nxt = stat.needs_read ? tcpq_pkg::STATUS_OK : tcpq_pkg::STATUS_EMPTY;
      end
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      urg_head_r <= '0;
      urg_tail_r <= '0;
      urg_cnt_r  <= '0;
      nrm_head_r <= '0;
      nrm_tail_r <= '0;
      nrm_cnt_r  <= '0;
    end else begin
      urg_head_r <= urg_head_nxt;
      urg_tail_r <= urg_tail_nxt;
      urg_cnt_r  <= urg_cnt_nxt;
      nrm_head_r <= nrm_head_nxt;
      nrm_tail_r <= nrm_tail_nxt;
      nrm_cnt_r  <= nrm_cnt_nxt;
    end
  end

  // hold the result payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    vld_r     <= vld_nxt;
    uid_r     <= uid_nxt;
    urg_r     <= urg_nxt;
    sel_urg_r <= sel_urg_nxt;
  end

  assign out_status    = status_r;
  assign out_out_valid = vld_r;
  assign out_uid       = uid_r;
  assign out_urgent    = urg_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (urg_cnt_r <= CW'(CLASS_DEPTH)) && (nrm_cnt_r <= CW'(CLASS_DEPTH)))
    else $error("class occupancy above its depth");

  a_urg_first: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem_nrm |-> urg_empty)
    else $error("normal entry removed while an urgent entry waits");

  a_urg_rem_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_rem_urg |=> (urg_cnt_r == $past(urg_cnt_r) - CW'(1)))
    else $error("urgent count not reduced after an urgent remove");

  a_load_marks_class: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ram |=> (vld_r && (urg_r == $past(sel_urg_r))))
    else $error("removed entry delivered with the wrong class");

endmodule
